[sv/hrcs_pkg.sv]
`timescale 1ns / 1ps

package hrcs_pkg;

    localparam int COUNT_WIDTH = 31;
    localparam int OUT_WIDTH   = 31;
    localparam int KEY_LEN     = 15;
    localparam int KEY_POS_W   = $clog2(KEY_LEN + 1);

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    // value scan phases
    typedef enum logic [3:0] {
        PH_SEARCH    = 4'b0001,
        PH_SKIP_WS   = 4'b0010,
        PH_DIGITS    = 4'b0100,
        PH_SKIP_REST = 4'b1000
    } phase_t;

    // header terminator progress
    typedef enum logic [3:0] {
        TM_NONE    = 4'b0001,
        TM_CR      = 4'b0010,
        TM_CRLF    = 4'b0100,
        TM_CRLFCR  = 4'b1000
    } term_t;

    function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

endpackage

[sv/http_request_completeness_scanner_top.sv]
`timescale 1ns / 1ps

// http request completeness scanner
// input channel: one request byte per transfer (data_byte) with last_byte
// marking the final byte received so far; in_valid / in_stall handshake.
// output channel: one result per last byte (complete, header_ended,
// length_present, declared_length, body_bytes); out_valid / out_stall.
// throughput: one byte per cycle while in_stall is low. a byte is captured in an
// input register, then scanned from there and, if it is a last byte, its result
// lands in the output register, which drives out_valid.
// the scan step is one compare on the key character, a terminator step and a
// multiply by ten with saturation on the 31-bit length.
// when the receiver stalls, bytes without last_byte keep flowing; a last byte
// waits in the input register until the output register is free, and in_stall
// is raised toward the sender for as long as it waits.
// after a last byte the scan state returns to its reset value.
// reset (rst_n low, asynchronous) clears all scan state and both valids.
module http_request_completeness_scanner_top
    import hrcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 complete,
    output logic                 header_ended,
    output logic                 length_present,
    output logic [OUT_WIDTH-1:0] declared_length,
    output logic [OUT_WIDTH-1:0] body_bytes
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_last_reg;

    logic [KEY_POS_W-1:0]   key_pos_reg, key_pos_next;
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] length_reg, length_next;
    logic                   length_seen_reg, length_seen_next;
    term_t                  term_reg, term_next;
    logic                   header_done_reg, header_done_next;
    logic [COUNT_WIDTH-1:0] body_reg, body_next;

    logic                   out_valid_reg;
    logic                   complete_reg;
    logic                   header_ended_reg;
    logic                   length_present_reg;
    logic [OUT_WIDTH-1:0]   declared_length_reg;
    logic [OUT_WIDTH-1:0]   body_bytes_reg;

    logic                   advance;
    logic                   accept;
    logic [7:0]             lc;
    logic [3:0]             digit;
    logic [COUNT_WIDTH+3:0] times_ten;

    // a non-last byte never needs the output slot
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign lc        = to_lower(s1_byte_reg);
    assign digit     = s1_byte_reg[3:0];
    assign times_ten = ({4'b0, length_reg} << 3) + ({4'b0, length_reg} << 1)
                       + {{COUNT_WIDTH{1'b0}}, digit};

    always_comb
    begin
        key_pos_next     = key_pos_reg;
        phase_next       = phase_reg;
        length_next      = length_reg;
        length_seen_next = length_seen_reg;
        term_next        = term_reg;
        header_done_next = header_done_reg;
        body_next        = body_reg;

        if (header_done_reg)
        begin
            if (body_reg != COUNT_MAX)
                body_next = body_reg + 1'b1;
        end
        else
        begin
            if (!length_seen_reg)
            begin
                unique case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (lc == key_char(key_pos_reg))
                        begin
                            if (key_pos_reg == KEY_POS_W'(KEY_LEN - 1))
                            begin
                                key_pos_next = '0;
                                phase_next   = PH_SKIP_WS;
                            end
                            else
                                key_pos_next = key_pos_reg + 1'b1;
                        end
                        else
                            key_pos_next = (lc == key_char('0)) ? KEY_POS_W'(1) : '0;
                    end
                    PH_SKIP_WS:
                    begin
                        if (!is_ws(s1_byte_reg))
                        begin
                            if (is_digit(s1_byte_reg))
                            begin
                                length_next = COUNT_WIDTH'(digit);
                                phase_next  = PH_DIGITS;
                            end
                            else
                                phase_next = PH_SKIP_REST;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_ws(s1_byte_reg))
                            length_seen_next = 1'b1;
                        else if (is_digit(s1_byte_reg))
                        begin
                            // saturate when the product leaves the count range
                            if (times_ten[COUNT_WIDTH+3:COUNT_WIDTH] != '0)
                                length_next = COUNT_MAX;
                            else
                                length_next = times_ten[COUNT_WIDTH-1:0];
                        end
                        else
                            phase_next = PH_SKIP_REST;
                    end
                    PH_SKIP_REST:
                    begin
                        if (is_ws(s1_byte_reg))
                            length_seen_next = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_SEARCH;
                    end
                endcase
            end

            unique case (term_reg)
                TM_NONE:
                    term_next = (s1_byte_reg == CHAR_CR) ? TM_CR : TM_NONE;
                TM_CR:
                    term_next = (s1_byte_reg == CHAR_LF) ? TM_CRLF :
                                (s1_byte_reg == CHAR_CR) ? TM_CR : TM_NONE;
                TM_CRLF:
                    term_next = (s1_byte_reg == CHAR_CR) ? TM_CRLFCR : TM_NONE;
                TM_CRLFCR:
                begin
                    if (s1_byte_reg == CHAR_LF)
                    begin
                        header_done_next = 1'b1;
                        term_next        = TM_NONE;
                    end
                    else
                        term_next = (s1_byte_reg == CHAR_CR) ? TM_CR : TM_NONE;
                end
                default:
                    term_next = TM_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            key_pos_reg     <= '0;
            phase_reg       <= PH_SEARCH;
            length_reg      <= '0;
            length_seen_reg <= 1'b0;
            term_reg        <= TM_NONE;
            header_done_reg <= 1'b0;
            body_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                if (s1_last_reg)
                begin
                    key_pos_reg     <= '0;
                    phase_reg       <= PH_SEARCH;
                    length_reg      <= '0;
                    length_seen_reg <= 1'b0;
                    term_reg        <= TM_NONE;
                    header_done_reg <= 1'b0;
                    body_reg        <= '0;
                end
                else
                begin
                    key_pos_reg     <= key_pos_next;
                    phase_reg       <= phase_next;
                    length_reg      <= length_next;
                    length_seen_reg <= length_seen_next;
                    term_reg        <= term_next;
                    header_done_reg <= header_done_next;
                    body_reg        <= body_next;
                end
            end

            if (advance && s1_last_reg)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (advance && s1_last_reg)
        begin
            complete_reg        <= header_done_next &&
                                   (!length_seen_next || body_next >= length_next);
            header_ended_reg    <= header_done_next;
            length_present_reg  <= length_seen_next;
            declared_length_reg <= length_seen_next ? OUT_WIDTH'(length_next) : '0;
            body_bytes_reg      <= OUT_WIDTH'(body_next);
        end
    end

    assign out_valid       = out_valid_reg;
    assign complete        = complete_reg;
    assign header_ended    = header_ended_reg;
    assign length_present  = length_present_reg;
    assign declared_length = declared_length_reg;
    assign body_bytes      = body_bytes_reg;

endmodule

[sv/hrcs_checker.sv]
`timescale 1ns / 1ps

module hrcs_checker
    import hrcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 complete,
    input  logic                 header_ended,
    input  logic                 length_present,
    input  logic [OUT_WIDTH-1:0] declared_length,
    input  logic [OUT_WIDTH-1:0] body_bytes
);

    // a stalled result stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(complete) && $stable(header_ended)
            && $stable(length_present) && $stable(declared_length)
            && $stable(body_bytes))
        else $error("result payload changed while stalled");

    // a request can only be complete once its header has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && complete |-> header_ended)
        else $error("complete without header terminator");

    // no length header means a zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !length_present |-> declared_length == '0)
        else $error("declared length without length header");

    // body bytes are only counted after the terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !header_ended |-> body_bytes == '0 && !complete)
        else $error("body bytes counted inside the header");

endmodule

bind http_request_completeness_scanner_top hrcs_checker u_hrcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .complete        (complete),
    .header_ended    (header_ended),
    .length_present  (length_present),
    .declared_length (declared_length),
    .body_bytes      (body_bytes)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import hrcs_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_BYTES = 1000;
    localparam int          MIN_REQUESTS = 16;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [63:0] LEN_MAX      = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [8*KEY_LEN-1:0] LENGTH_KEY = "content-length:";

    typedef struct packed {
        logic                 complete;
        logic                 header_ended;
        logic                 length_present;
        logic [OUT_WIDTH-1:0] declared_length;
        logic [OUT_WIDTH-1:0] body_bytes;
    } scan_verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'h00;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 complete;
    logic                 header_ended;
    logic                 length_present;
    logic [OUT_WIDTH-1:0] declared_length;
    logic [OUT_WIDTH-1:0] body_bytes;

    // scanner copy kept by the bench
    int                     key_pos = 0;
    phase_t                 scan_phase = PH_SEARCH;
    logic [COUNT_WIDTH-1:0] len_value = '0;
    logic                   len_seen = 1'b0;
    term_t                  term_state = TM_NONE;
    logic                   hdr_done = 1'b0;
    logic [COUNT_WIDTH-1:0] body_count = '0;

    scan_verdict_t pending_verdicts[$];
    logic [7:0]    req_bytes[$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          rx_gap = 0;
    int          hold_left = 0;
    logic        tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;

    http_request_completeness_scanner_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .complete        (complete),
        .header_ended    (header_ended),
        .length_present  (length_present),
        .declared_length (declared_length),
        .body_bytes      (body_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] r;
        r = $urandom_range(0, 255);
        return r;
    endfunction

    task automatic clear_scan();
        key_pos    = 0;
        scan_phase = PH_SEARCH;
        len_value  = '0;
        len_seen   = 1'b0;
        term_state = TM_NONE;
        hdr_done   = 1'b0;
        body_count = '0;
    endtask

    task automatic predict_scan(input logic [7:0] b, input logic fin);
        logic [7:0]    lc;
        logic [63:0]   grown;
        scan_verdict_t verdict;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (hdr_done)
        begin
            if (body_count != {COUNT_WIDTH{1'b1}})
                body_count = body_count + 1'b1;
        end
        else
        begin
            if (!len_seen)
            begin
                case (scan_phase)
                    PH_SEARCH:
                    begin
                        if (key_pos < KEY_LEN && lc == LENGTH_KEY[8*(KEY_LEN-1-key_pos) +: 8])
                        begin
                            key_pos++;
                            if (key_pos == KEY_LEN)
                            begin
                                key_pos    = 0;
                                scan_phase = PH_SKIP_WS;
                            end
                        end
                        else
                            key_pos = (lc == "c") ? 1 : 0;
                    end
                    PH_SKIP_WS:
                    begin
                        if (!blank(b))
                        begin
                            if (b >= "0" && b <= "9")
                            begin
                                len_value  = b - "0";
                                scan_phase = PH_DIGITS;
                            end
                            else
                                scan_phase = PH_SKIP_REST;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (blank(b))
                            len_seen = 1'b1;
                        else if (b >= "0" && b <= "9")
                        begin
                            grown     = len_value;
                            grown     = grown * 10 + (b - "0");
                            len_value = (grown > LEN_MAX) ? LEN_MAX[COUNT_WIDTH-1:0]
                                                          : grown[COUNT_WIDTH-1:0];
                        end
                        else
                            scan_phase = PH_SKIP_REST;
                    end
                    default:
                    begin
                        if (blank(b))
                            len_seen = 1'b1;
                    end
                endcase
            end
            case (term_state)
                TM_NONE:
                    term_state = (b == CHAR_CR) ? TM_CR : TM_NONE;
                TM_CR:
                    term_state = (b == CHAR_LF) ? TM_CRLF : (b == CHAR_CR) ? TM_CR : TM_NONE;
                TM_CRLF:
                    term_state = (b == CHAR_CR) ? TM_CRLFCR : TM_NONE;
                default:
                begin
                    if (b == CHAR_LF)
                    begin
                        hdr_done   = 1'b1;
                        term_state = TM_NONE;
                    end
                    else
                        term_state = (b == CHAR_CR) ? TM_CR : TM_NONE;
                end
            endcase
        end
        if (fin)
        begin
            verdict.complete        = hdr_done && (!len_seen || body_count >= len_value);
            verdict.header_ended    = hdr_done;
            verdict.length_present  = len_seen;
            verdict.declared_length = len_seen ? len_value : '0;
            verdict.body_bytes      = body_count;
            pending_verdicts.push_back(verdict);
            clear_scan();
        end
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_scan(b, fin);
        @(negedge clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endtask

    task automatic add_line(input string s);
        add_text(s);
        req_bytes.push_back(CHAR_CR);
        req_bytes.push_back(CHAR_LF);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++)
            send_byte(req_bytes[i], i == req_bytes.size() - 1);
        req_bytes.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_header_forms();
        add_line("GET / HTTP/1.1");
        add_line("Content-Length: 3");
        add_line("");
        add_text("abc");
        send_request();
        add_line("GET /");
        add_line("Host: h1");
        add_line("");
        send_request();
        // header never ends
        add_line("GET /");
        add_text("content-length: 5");
        send_request();
        // terminator arrives while skipping blanks before the value
        add_text("content-length:");
        add_line("");
        add_line("");
        add_text("zz");
        send_request();
        // key after the header is body
        add_line("GET /");
        add_line("");
        add_line("content-length: 9");
        send_request();
        add_text("\015\015\012\015\012");
        send_request();
        add_text("\012\015\012\015\012\015\012\015\015\012\015\012q");
        send_request();
        req_bytes.push_back(8'h00);
        send_request();
        req_bytes.push_back(8'hff);
        send_request();
        // partial key then restart on c
        add_text("content-lengtcontent-length: 2");
        add_line("");
        add_line("");
        add_text("ab");
        send_request();
        add_text("ccontent-length:");
        add_line("\t 4");
        add_line("");
        add_text("wxyz");
        send_request();
        add_line("CONTENT-LENGTH: 1 content-length: 9");
        add_line("");
        add_text("x");
        send_request();
    endtask

    task automatic test_length_values();
        string vals[10];
        vals = '{"0", "007", "-5", "+5", "12ab", "abc", "2147483647", "2147483648",
                 "99999999999", "21474836470"};
        foreach (vals[i])
        begin
            add_line("POST /form");
            add_text("Content-Length: ");
            add_line(vals[i]);
            add_line("");
            add_text("xy");
            send_request();
        end
        wait_drained();
    endtask

    task automatic make_random_request();
        int          kind;
        int          n;
        int          spot;
        logic [63:0] v;
        string       num;
        string       key;
        req_bytes.delete();
        kind = $urandom_range(0, 11);
        if (kind == 0)
        begin
            n = $urandom_range(1, 20);
            repeat (n) req_bytes.push_back(rand_byte());
            return;
        end
        add_line($urandom_range(0, 1) ? "GET /index HTTP/1.1" : "POST /form HTTP/1.0");
        if ($urandom_range(0, 1))
            add_line("Host: h1");
        key = "content-length:";
        for (int i = 0; i < key.len(); i++)
            if ($urandom_range(0, 1) && key[i] >= "a" && key[i] <= "z")
                key[i] = key[i] - 8'd32;
        if (kind == 1)
            key[$urandom_range(0, key.len() - 1)] = "x";
        if (kind == 2)
            key = {key.substr(0, $urandom_range(0, 12)), key};
        add_text(key);
        repeat ($urandom_range(0, 2)) add_text($urandom_range(0, 1) ? " " : "\t");
        case ($urandom_range(0, 5))
            0:       v = {$urandom, $urandom};
            1:       v = $urandom;
            default: v = $urandom_range(0, 12);
        endcase
        num = $sformatf("%0d", v);
        if (kind == 3)
            num = {"-", num};
        if (kind == 4)
            num = {num, "q7"};
        add_text(num);
        if (kind == 5)
            add_text(" extra");
        req_bytes.push_back(CHAR_CR);
        req_bytes.push_back(CHAR_LF);
        if ($urandom_range(0, 1))
            add_line("Accept: */*");
        if (kind != 6)
            add_line("");
        n = $urandom_range(0, 8);
        if (v < 16)
            n = int'(v) + $urandom_range(0, 2) - 1;
        if (n < 0)
            n = 0;
        repeat (n) req_bytes.push_back(rand_byte());
        if (kind == 7)
            add_line("content-length: 3");
        if (kind == 8 && req_bytes.size() > 1)
        begin
            spot = $urandom_range(1, req_bytes.size() - 1);
            while (req_bytes.size() > spot)
                void'(req_bytes.pop_back());
        end
    endtask

    task automatic test_random_requests();
        int sent;
        int made;
        sent = 0;
        made = 0;
        while (sent < RANDOM_BYTES || made < MIN_REQUESTS)
        begin
            // switch idling on and off for stretches
            if ($urandom_range(0, 7) == 0)
            begin
                tx_idle_on = $urandom_range(0, 1);
                rx_idle_on = $urandom_range(0, 1);
            end
            make_random_request();
            sent += req_bytes.size();
            made++;
            send_request();
            if (made % 16 == 0)
                wait_drained();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver blocks long enough for the scanner to back up into the sender
    task automatic test_receiver_hold();
        hold_left <= HOLD_CYCLES;
        tx_idle_on = 1'b0;
        repeat (6)
        begin
            add_line("GET /");
            add_line("content-length: 2");
            add_line("");
            add_text("ok");
            send_request();
            req_bytes.push_back(CHAR_LF);
            send_request();
        end
        tx_idle_on = 1'b1;
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
    begin
        out_stall <= (rx_gap > 0) || (hold_left > 0);
        if (rx_gap > 0)
            rx_gap = rx_gap - 1;
    end

    always @(posedge clk)
    begin : result_check
        scan_verdict_t got;
        scan_verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {complete, header_ended, length_present, declared_length, body_bytes};
            if (pending_verdicts.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result at cycle %0d: %p", cycle_count, got);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.complete !== want.complete || got.header_ended !== want.header_ended
                    || got.length_present !== want.length_present
                    || got.declared_length !== want.declared_length
                    || got.body_bytes !== want.body_bytes)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch at cycle %0d: expected %p, got %p",
                                 cycle_count, want, got);
                end
            end
            rx_gap = rx_idle_on ? $urandom_range(0, 8) : 0;
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_header_forms();
        test_length_values();
        test_receiver_hold();
        test_random_requests();
        wait_drained();
        repeat (10) @(negedge clk);
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
